// ----- src/timed_task_queue_core_macros.svh -----
// Assertion macros for the timed task queue core checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TIMED_TASK_QUEUE_CORE_MACROS_SVH
`define TIMED_TASK_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TTQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed task queue check failed");

// Next-cycle implication, disabled while reset is high.
`define TTQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed task queue check failed");

`endif

// ----- src/ttq_pkg.sv -----
// Shared constants, codes and types for the timed task queue core.
// Used by every module of the block. No dependencies.
`timescale 1ns / 1ps
package ttq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_BITS      = 8;
   localparam int IDX_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_BITS    = 32;
   localparam int FUNC_BITS    = 2;
   localparam int TASK_ID_BITS = 8;
   localparam int VAL_BITS     = 16;
   localparam int OUT_ID_BITS  = 8;

   localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd2;

   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_REJECT   = 1'b1;

   typedef logic [IDX_BITS-1:0] idx_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] due;
      logic [VAL_BITS-1:0]  period;
      logic [VAL_BITS-1:0]  length;
   } entry_type;

   // table write / read controls from the sequencer
   typedef struct packed {
      logic      wr_en;
      logic      clr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      idx_type   rd_addr;
   } store_ctrl_type;

   typedef struct packed {
      logic    clr;
      logic    live;
      idx_type idx;
   } scan_ctrl_type;

   typedef struct packed {
      logic                match;
      idx_type             match_idx;
      logic                free;
      idx_type             free_idx;
      logic [CNT_BITS-1:0] due_count;
      idx_type             best_idx;
      entry_type           best;
   } scan_res_type;

endpackage

// ----- src/ttq_store.sv -----
// Task table: entry memory with a registered read port plus per-entry valid flops.
// Depends on ttq_pkg.
`timescale 1ns / 1ps
module ttq_store (
   input  logic                    clock,
   input  logic                    reset,
   input  ttq_pkg::store_ctrl_type ctrl,
   output ttq_pkg::entry_type      rd_entry,
   output logic                    rd_valid
);

   ttq_pkg::entry_type entry_mem [ttq_pkg::QUEUE_DEPTH];
   logic [ttq_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   ttq_pkg::entry_type rd_entry_ff;
   logic               rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.wr_en) begin
         valid_in[ctrl.wr_addr] = 1'b1;
      end
      if (ctrl.clr_en) begin
         valid_in[ctrl.wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entry_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_entry_ff <= entry_mem[ctrl.rd_addr];
      rd_valid_ff <= valid_ff[ctrl.rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ----- src/ttq_scan.sv -----
// Shared scan unit: one entry per cycle through a single age subtract and compare.
// Tracks id match, first free slot, due count and the earliest-due entry. Depends on ttq_pkg.
`timescale 1ns / 1ps
module ttq_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  ttq_pkg::scan_ctrl_type          ctrl,
   input  ttq_pkg::entry_type              rd_entry,
   input  logic                            rd_valid,
   input  logic [ttq_pkg::ID_BITS-1:0]     op_id,
   input  logic [ttq_pkg::TIME_BITS-1:0]   now,
   output ttq_pkg::scan_res_type           res
);

   ttq_pkg::scan_res_type res_ff, res_in;
   logic                           found_ff, found_in;
   logic [ttq_pkg::TIME_BITS-1:0]  best_age_ff, best_age_in;
   logic [ttq_pkg::TIME_BITS-1:0]  age;
   logic                           is_due;
   logic                           is_better;

   always_comb begin
      // modular age; due when it lands in the lower half of the range
      age       = now - rd_entry.due;
      is_due    = rd_valid && !age[ttq_pkg::TIME_BITS-1];
      is_better = !found_ff || (age > best_age_ff) ||
                  ((age == best_age_ff) && (rd_entry.id < res_ff.best.id));
      res_in      = res_ff;
      found_in    = found_ff;
      best_age_in = best_age_ff;
      if (ctrl.clr) begin
         res_in.match     = 1'b0;
         res_in.free      = 1'b0;
         res_in.due_count = '0;
         found_in         = 1'b0;
      end else if (ctrl.live) begin
         if (rd_valid && (rd_entry.id == op_id) && !res_ff.match) begin
            res_in.match     = 1'b1;
            res_in.match_idx = ctrl.idx;
         end
         if (!rd_valid && !res_ff.free) begin
            res_in.free     = 1'b1;
            res_in.free_idx = ctrl.idx;
         end
         if (is_due) begin
            res_in.due_count = res_ff.due_count + ttq_pkg::CNT_BITS'(1);
            if (is_better) begin
               found_in        = 1'b1;
               best_age_in     = age;
               res_in.best_idx = ctrl.idx;
               res_in.best     = rd_entry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         res_ff   <= res_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_age_ff <= best_age_in;
   end

   assign res = res_ff;

endmodule

// ----- src/timed_task_queue_core.sv -----
// Top level of the timed task queue: sequencer, time counter and result register.
// Instantiates ttq_store and ttq_scan; depends on ttq_pkg.
`timescale 1ns / 1ps
// One item is worked at a time; req_stall is high while it is in progress. Every add,
// remove or tick costs a scan of the whole table through the single registered read
// port of the entry memory, one entry per cycle; an add to a full table then emits a
// reject beat. A tick dispatches every due task, each dispatch after the first one
// picked by a fresh scan for the earliest-due entry; a dispatch waits while the
// result side stalls. Results sit in an output register, so a pending beat does not
// block the scan that picks the next one.
module timed_task_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ttq_pkg::FUNC_BITS-1:0]     req_func,
   input  logic [ttq_pkg::TASK_ID_BITS-1:0]  req_task_id,
   input  logic [ttq_pkg::VAL_BITS-1:0]      req_delay,
   input  logic [ttq_pkg::VAL_BITS-1:0]      req_period,
   input  logic [ttq_pkg::VAL_BITS-1:0]      req_run_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [ttq_pkg::OUT_ID_BITS-1:0]   rsp_out_id,
   output logic [ttq_pkg::VAL_BITS-1:0]      rsp_out_length,
   output logic                              rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [ttq_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                            live_ff, live_in;
   ttq_pkg::idx_type                idx_ff, idx_in;
   logic [ttq_pkg::TIME_BITS-1:0]   now_ff, now_in;
   logic                            reject_ff, reject_in;
   logic [ttq_pkg::FUNC_BITS-1:0]   op_func_ff, op_func_in;
   logic [ttq_pkg::ID_BITS-1:0]     op_id_ff, op_id_in;
   logic [ttq_pkg::VAL_BITS-1:0]    op_delay_ff, op_delay_in;
   logic [ttq_pkg::VAL_BITS-1:0]    op_period_ff, op_period_in;
   logic [ttq_pkg::VAL_BITS-1:0]    op_len_ff, op_len_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_kind_ff, rsp_kind_in;
   logic [ttq_pkg::OUT_ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [ttq_pkg::VAL_BITS-1:0]    rsp_len_ff, rsp_len_in;
   logic                            rsp_last_ff, rsp_last_in;

   ttq_pkg::store_ctrl_type st_ctrl;
   ttq_pkg::scan_ctrl_type  sc_ctrl;
   ttq_pkg::scan_res_type   sc_res;
   ttq_pkg::entry_type      rd_entry;
   logic                    rd_valid;
   logic                    scan_clr;
   logic                    in_range;
   logic                    out_free;
   logic                    tick_last;

   always_comb begin
      in_range  = cnt_ff < ttq_pkg::CNT_BITS'(ttq_pkg::QUEUE_DEPTH);
      out_free  = !rsp_valid_ff || !rsp_stall;
      tick_last = sc_res.due_count == ttq_pkg::CNT_BITS'(1);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      reject_in    = reject_ff;
      op_func_in   = op_func_ff;
      op_id_in     = op_id_ff;
      op_delay_in  = op_delay_ff;
      op_period_in = op_period_ff;
      op_len_in    = op_len_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      scan_clr     = 1'b0;

      st_ctrl         = '0;
      st_ctrl.rd_addr = in_range ? cnt_ff[ttq_pkg::IDX_BITS-1:0] : '0;
      live_in         = (state_ff == ST_SCAN) && in_range;
      idx_in          = st_ctrl.rd_addr;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_func_in   = req_func;
               op_id_in     = ttq_pkg::ID_BITS'(req_task_id);
               op_delay_in  = req_delay;
               op_period_in = req_period;
               op_len_in    = req_run_length;
               if (req_func == ttq_pkg::FUNC_TICK) begin
                  now_in = now_ff + ttq_pkg::TIME_BITS'(1);
               end
               // the unused func code is dropped here
               if (req_func == ttq_pkg::FUNC_ADD || req_func == ttq_pkg::FUNC_REMOVE ||
                   req_func == ttq_pkg::FUNC_TICK) begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
                  scan_clr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (in_range) begin
               cnt_in = cnt_ff + ttq_pkg::CNT_BITS'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            case (op_func_ff)
               ttq_pkg::FUNC_ADD: begin
                  if (sc_res.match || sc_res.free) begin
                     st_ctrl.wr_en          = 1'b1;
                     st_ctrl.wr_addr        = sc_res.match ? sc_res.match_idx
                                                           : sc_res.free_idx;
                     st_ctrl.wr_data.id     = op_id_ff;
                     st_ctrl.wr_data.due    = now_ff + ttq_pkg::TIME_BITS'(op_delay_ff);
                     st_ctrl.wr_data.period = op_period_ff;
                     st_ctrl.wr_data.length = op_len_ff;
                  end else begin
                     reject_in = 1'b1;
                     state_in  = ST_EMIT;
                  end
               end
               ttq_pkg::FUNC_REMOVE: begin
                  if (sc_res.match) begin
                     st_ctrl.clr_en  = 1'b1;
                     st_ctrl.wr_addr = sc_res.match_idx;
                  end
               end
               ttq_pkg::FUNC_TICK: begin
                  if (sc_res.due_count != '0) begin
                     reject_in = 1'b0;
                     state_in  = ST_EMIT;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (reject_ff) begin
                  rsp_kind_in = ttq_pkg::KIND_REJECT;
                  rsp_id_in   = ttq_pkg::OUT_ID_BITS'(op_id_ff);
                  rsp_len_in  = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_kind_in     = ttq_pkg::KIND_DISPATCH;
                  rsp_id_in       = ttq_pkg::OUT_ID_BITS'(sc_res.best.id);
                  rsp_len_in      = sc_res.best.length;
                  rsp_last_in     = tick_last;
                  st_ctrl.wr_addr = sc_res.best_idx;
                  // periodic tasks go back in; new due time is always in the future
                  if (sc_res.best.period != '0) begin
                     st_ctrl.wr_en       = 1'b1;
                     st_ctrl.wr_data     = sc_res.best;
                     st_ctrl.wr_data.due = now_ff +
                                           ttq_pkg::TIME_BITS'(sc_res.best.period);
                  end else begin
                     st_ctrl.clr_en = 1'b1;
                  end
                  if (tick_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_SCAN;
                     cnt_in   = '0;
                     scan_clr = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      sc_ctrl.clr  = scan_clr;
      sc_ctrl.live = live_ff;
      sc_ctrl.idx  = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         live_ff      <= 1'b0;
         now_ff       <= '0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         live_ff      <= live_in;
         now_ff       <= now_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      op_func_ff   <= op_func_in;
      op_id_ff     <= op_id_in;
      op_delay_ff  <= op_delay_in;
      op_period_ff <= op_period_in;
      op_len_ff    <= op_len_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   ttq_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (st_ctrl),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   ttq_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sc_ctrl),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid),
      .op_id    (op_id_ff),
      .now      (now_ff),
      .res      (sc_res)
   );

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_out_length = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- src/ttq_checker.sv -----
// Port-level checker for timed_task_queue_core, attached by the bind at the bottom.
// Depends on ttq_pkg and timed_task_queue_core_macros.svh.
`timescale 1ns / 1ps
`include "timed_task_queue_core_macros.svh"
module ttq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [ttq_pkg::FUNC_BITS-1:0]     req_func,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_kind,
   input logic [ttq_pkg::OUT_ID_BITS-1:0]   rsp_out_id,
   input logic [ttq_pkg::VAL_BITS-1:0]      rsp_out_length,
   input logic                              rsp_last
);

   // a reject is always a lone beat with no length
   `TTQ_ASSERT_IMPL(a_reject_shape, rsp_valid && rsp_kind == ttq_pkg::KIND_REJECT, rsp_last && rsp_out_length == '0)

   // more dispatches pending for this tick: input side must stay closed
   `TTQ_ASSERT_IMPL(a_busy_mid_tick, rsp_valid && !rsp_last, req_stall)

   `TTQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall && (req_func == ttq_pkg::FUNC_ADD || req_func == ttq_pkg::FUNC_REMOVE || req_func == ttq_pkg::FUNC_TICK), req_stall)

   `TTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_id) && $stable(rsp_out_length) && $stable(rsp_last))

endmodule

bind timed_task_queue_core ttq_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_out_id     (rsp_out_id),
   .rsp_out_length (rsp_out_length),
   .rsp_last       (rsp_last)
);

// ----- test/tb_timed_task_queue_core.sv -----
// Self-checking testbench for timed_task_queue_core: directed and random adds, removes and ticks.
// Predicts dispatch order and rejects with its own task table; depends on ttq_pkg and timed_task_queue_core.
`timescale 1ns / 1ps
module tb_timed_task_queue_core;

   localparam logic [ttq_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [ttq_pkg::TIME_BITS-1:0] HALF_RANGE   = 32'h8000_0000;
   localparam int NO_SLOT      = -1;
   localparam int POOL_SIZE    = 20;
   localparam int RANDOM_ITEMS = 320;
   localparam int QUIET_ITEMS  = 60;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 2 * ttq_pkg::QUEUE_DEPTH + 40;

   typedef struct packed {
      logic                            kind;
      logic [ttq_pkg::OUT_ID_BITS-1:0] id;
      logic [ttq_pkg::VAL_BITS-1:0]    length;
      logic                            last;
   } result_beat_type;

   class task_table_predictor_type;
      logic [ttq_pkg::TIME_BITS-1:0] now_count;
      bit                            in_use[ttq_pkg::QUEUE_DEPTH];
      logic [ttq_pkg::ID_BITS-1:0]   slot_id[ttq_pkg::QUEUE_DEPTH];
      logic [ttq_pkg::TIME_BITS-1:0] slot_due[ttq_pkg::QUEUE_DEPTH];
      logic [ttq_pkg::VAL_BITS-1:0]  slot_period[ttq_pkg::QUEUE_DEPTH];
      logic [ttq_pkg::VAL_BITS-1:0]  slot_length[ttq_pkg::QUEUE_DEPTH];
      result_beat_type               pending_beats[$];
      int                            errors;

      function new();
         now_count = '0;
         foreach (in_use[i]) in_use[i] = 1'b0;
         errors = 0;
      endfunction

      function int find_slot(logic [ttq_pkg::ID_BITS-1:0] id);
         for (int i = 0; i < ttq_pkg::QUEUE_DEPTH; i++)
            if (in_use[i] && slot_id[i] == id) return i;
         return NO_SLOT;
      endfunction

      // older due time first, lower id on ties
      function bit goes_first(int a, int b);
         logic [ttq_pkg::TIME_BITS-1:0] age_a, age_b;
         age_a = now_count - slot_due[a];
         age_b = now_count - slot_due[b];
         if (age_a != age_b) return age_a > age_b;
         return slot_id[a] < slot_id[b];
      endfunction

      function void note_request(logic [ttq_pkg::FUNC_BITS-1:0] func,
                                 logic [ttq_pkg::TASK_ID_BITS-1:0] task_id,
                                 logic [ttq_pkg::VAL_BITS-1:0] delay,
                                 logic [ttq_pkg::VAL_BITS-1:0] period,
                                 logic [ttq_pkg::VAL_BITS-1:0] run_length);
         int slot, best, e;
         int due_slots[$];
         logic [ttq_pkg::ID_BITS-1:0] id;
         id = task_id[ttq_pkg::ID_BITS-1:0];
         case (func)
            ttq_pkg::FUNC_ADD: begin
               slot = find_slot(id);
               if (slot == NO_SLOT)
                  for (int i = ttq_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
                     if (!in_use[i]) slot = i;
               if (slot == NO_SLOT) begin
                  pending_beats.push_back('{ttq_pkg::KIND_REJECT,
                                            ttq_pkg::OUT_ID_BITS'(id), '0, 1'b1});
               end else begin
                  in_use[slot]      = 1'b1;
                  slot_id[slot]     = id;
                  slot_due[slot]    = now_count + ttq_pkg::TIME_BITS'(delay);
                  slot_period[slot] = period;
                  slot_length[slot] = run_length;
               end
            end
            ttq_pkg::FUNC_REMOVE: begin
               slot = find_slot(id);
               if (slot != NO_SLOT) in_use[slot] = 1'b0;
            end
            ttq_pkg::FUNC_TICK: begin
               now_count++;
               for (int i = 0; i < ttq_pkg::QUEUE_DEPTH; i++)
                  if (in_use[i] && (now_count - slot_due[i]) < HALF_RANGE)
                     due_slots.push_back(i);
               while (due_slots.size() != 0) begin
                  best = 0;
                  for (int k = 1; k < due_slots.size(); k++)
                     if (goes_first(due_slots[k], due_slots[best])) best = k;
                  e = due_slots[best];
                  due_slots.delete(best);
                  pending_beats.push_back('{ttq_pkg::KIND_DISPATCH,
                                            ttq_pkg::OUT_ID_BITS'(slot_id[e]),
                                            slot_length[e], due_slots.size() == 0});
                  if (slot_period[e] != 0)
                     slot_due[e] = now_count + ttq_pkg::TIME_BITS'(slot_period[e]);
                  else
                     in_use[e] = 1'b0;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(logic kind, logic [ttq_pkg::OUT_ID_BITS-1:0] id,
                               logic [ttq_pkg::VAL_BITS-1:0] length, logic last);
         result_beat_type want;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d id %0h",
                     $time, kind, id, " len %0h last %0d", length, last);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         compare_field("kind", want.kind, kind);
         compare_field("out_id", want.id, id);
         compare_field("out_length", want.length, length);
         compare_field("last", want.last, last);
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [ttq_pkg::FUNC_BITS-1:0]    req_func;
   logic [ttq_pkg::TASK_ID_BITS-1:0] req_task_id;
   logic [ttq_pkg::VAL_BITS-1:0]     req_delay;
   logic [ttq_pkg::VAL_BITS-1:0]     req_period;
   logic [ttq_pkg::VAL_BITS-1:0]     req_run_length;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_kind;
   logic [ttq_pkg::OUT_ID_BITS-1:0]  rsp_out_id;
   logic [ttq_pkg::VAL_BITS-1:0]     rsp_out_length;
   logic                             rsp_last;

   task_table_predictor_type         predictor = new();
   bit                               idle_on = 1'b1;
   int                               quiet_cycles = 0;
   logic [ttq_pkg::TASK_ID_BITS-1:0] id_pool[POOL_SIZE];

   timed_task_queue_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_task_id    (req_task_id),
      .req_delay      (req_delay),
      .req_period     (req_period),
      .req_run_length (req_run_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_length (rsp_out_length),
      .rsp_last       (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_item(input logic [ttq_pkg::FUNC_BITS-1:0] func,
                            input logic [ttq_pkg::TASK_ID_BITS-1:0] id,
                            input logic [ttq_pkg::VAL_BITS-1:0] delay,
                            input logic [ttq_pkg::VAL_BITS-1:0] period,
                            input logic [ttq_pkg::VAL_BITS-1:0] run_length);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_task_id    <= id;
      req_delay      <= delay;
      req_period     <= period;
      req_run_length <= run_length;
      do @(posedge clock); while (req_stall);
      predictor.note_request(func, id, delay, period, run_length);
   endtask

   // result side back-pressure
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_beat(rsp_kind, rsp_out_id, rsp_out_length, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int n, pick;
      logic [ttq_pkg::FUNC_BITS-1:0]    f;
      logic [ttq_pkg::TASK_ID_BITS-1:0] id;
      logic [ttq_pkg::VAL_BITS-1:0]     d, p;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= ttq_pkg::FUNC_ADD;
      req_task_id    <= '0;
      req_delay      <= '0;
      req_period     <= '0;
      req_run_length <= '0;
      foreach (id_pool[i]) id_pool[i] = ttq_pkg::TASK_ID_BITS'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, unused code, stray remove, tie ordering, overwrite, full table
      send_item(ttq_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      send_item(FUNC_UNUSED, 8'hA5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ttq_pkg::FUNC_REMOVE, 8'h77, 16'h0000, 16'h0000, 16'h0000);
      send_item(ttq_pkg::FUNC_ADD, 8'hFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_item(ttq_pkg::FUNC_ADD, 8'h00, 16'h0000, 16'h0001, 16'h0000);
      send_item(ttq_pkg::FUNC_ADD, 8'h05, 16'h0001, 16'hFFFF, 16'h1234);
      send_item(ttq_pkg::FUNC_ADD, 8'h80, 16'hFFFF, 16'h0000, 16'hAAAA);
      send_item(ttq_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      send_item(ttq_pkg::FUNC_ADD, 8'h00, 16'h0000, 16'h0000, 16'h5555);
      send_item(ttq_pkg::FUNC_REMOVE, 8'h05, 16'h0000, 16'h0000, 16'h0000);
      send_item(ttq_pkg::FUNC_REMOVE, 8'h80, 16'h0000, 16'h0000, 16'h0000);
      for (int i = 0; i < ttq_pkg::QUEUE_DEPTH - 1; i++)
         send_item(ttq_pkg::FUNC_ADD, ttq_pkg::TASK_ID_BITS'(8'h10 + i * 11),
                   16'h0000, 16'h0000, ttq_pkg::VAL_BITS'(16'h0100 * i + 16'h00F0));
      // overwrite while full, then no room, then a tick that drains all slots
      send_item(ttq_pkg::FUNC_ADD, 8'h10, 16'h0000, 16'h0000, 16'h0F0F);
      send_item(ttq_pkg::FUNC_ADD, 8'h42, 16'h0003, 16'h0002, 16'h3333);
      send_item(ttq_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         idle_on = (n < 150 || n >= 190) && (n < RANDOM_ITEMS - QUIET_ITEMS);
         pick = $urandom_range(0, 99);
         if (pick < 42) f = ttq_pkg::FUNC_ADD;
         else if (pick < 57) f = ttq_pkg::FUNC_REMOVE;
         else if (pick < 96) f = ttq_pkg::FUNC_TICK;
         else f = FUNC_UNUSED;
         case ($urandom_range(0, 9))
            0, 1, 2: p = '0;
            9:       p = ttq_pkg::VAL_BITS'($urandom);
            default: p = ttq_pkg::VAL_BITS'($urandom_range(1, 5));
         endcase
         d = ($urandom_range(0, 9) == 0) ? ttq_pkg::VAL_BITS'($urandom)
                                         : ttq_pkg::VAL_BITS'($urandom_range(0, 6));
         if ($urandom_range(0, 4) == 0 && f != ttq_pkg::FUNC_REMOVE) begin
            // ids outside the pool never get removed, so keep them short-lived
            id = ttq_pkg::TASK_ID_BITS'($urandom);
            p  = '0;
            d  = ttq_pkg::VAL_BITS'($urandom_range(0, 6));
         end else begin
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         send_item(f, id, d, p, ttq_pkg::VAL_BITS'($urandom));
         n++;
      end
      req_valid <= 1'b0;
      idle_on = 1'b0;

      while (predictor.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predictor.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
